FILE: rtl/mts_pkg.sv
package mts_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int WORD_W       = 32;
    localparam int CORNER_WORDS = 11;
    localparam int DATA_W       = WORD_W * CORNER_WORDS;
    localparam int SUM_W        = WORD_W + 1;
    localparam int SQ_W         = 2 * SUM_W;
    localparam int LEN_W        = SQ_W;
    localparam int ACC_W        = 2 * FRAC_BITS + LEN_W + 4;
    localparam int Q_W          = FRAC_BITS + 1;
    localparam int STEP_W       = $clog2(FRAC_BITS + 1);
    localparam int RUN_LEN      = 6;
    localparam int CNT_W        = 3;

    localparam int W_NORM = 3;
    localparam int W_TAN  = 6;
    localparam int W_U    = 9;
    localparam int W_V    = 10;

    typedef logic [CORNER_WORDS-1:0][WORD_W-1:0] t_corner;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_SQ,
        S_LOAD,
        S_ITER,
        S_STORE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             corner_we;
        logic [1:0]       corner_slot;
        logic [1:0]       pair;
        logic             vec;
        logic [1:0]       comp;
        logic             sq_en;
        logic             sq_first;
        logic             load_en;
        logic             iter_en;
        logic             store_en;
        logic             out_load;
        logic [CNT_W-1:0] out_sel;
        logic             out_last;
    } t_cmd;

endpackage

FILE: rtl/mts_datapath.sv
module mts_datapath
    import mts_pkg::*;
(
    input  logic              i_clk,
    input  t_cmd              i_cmd,
    input  logic [DATA_W-1:0] i_corner,
    output logic [DATA_W-1:0] o_data,
    output logic              o_last
);

    t_corner r_corner [0:2];
    logic [WORD_W-1:0] r_res [0:2][0:1][0:2];

    logic [LEN_W-1:0] r_len;
    logic [ACC_W-1:0] r_rhs, r_p, r_a, r_b;
    logic [Q_W-1:0]   r_q, r_bit;
    logic             r_neg;
    logic [DATA_W-1:0] r_odata;
    logic             r_olast;

    t_corner           a_w, b_w, mid;
    logic [3:0]        widx;
    logic [SUM_W-1:0]  s, mag;
    logic [SQ_W-1:0]   sq;
    logic [ACC_W-1:0]  t;
    logic              fit;
    logic [WORD_W-1:0] qv, res;

    function automatic logic [WORD_W-1:0] half_sum(input logic [WORD_W-1:0] x,
                                                   input logic [WORD_W-1:0] y);
        logic [SUM_W-1:0] h;
        h = {x[WORD_W-1], x} + {y[WORD_W-1], y};
        return h[SUM_W-1:1];
    endfunction

    always_comb begin
        a_w  = (i_cmd.pair == 2'd1) ? r_corner[1] : r_corner[0];
        b_w  = (i_cmd.pair == 2'd0) ? r_corner[1] : r_corner[2];
        widx = 4'(W_NORM) + (i_cmd.vec ? 4'(W_TAN - W_NORM) : 4'd0) + {2'b00, i_cmd.comp};
        s    = {a_w[widx][WORD_W-1], a_w[widx]} + {b_w[widx][WORD_W-1], b_w[widx]};
        mag  = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
        sq   = SQ_W'(mag) * SQ_W'(mag);
        t    = r_p + r_a + r_b;
        fit  = (t <= r_rhs);
        qv   = WORD_W'(r_q);
        res  = (r_len == '0) ? '0 : (r_neg ? (~qv + WORD_W'(1)) : qv);
        mid  = '0;
        for (int i = 0; i < 3; i++) begin
            mid[i]          = half_sum(a_w[i], b_w[i]);
            mid[W_NORM + i] = r_res[i_cmd.pair][0][i];
            mid[W_TAN + i]  = r_res[i_cmd.pair][1][i];
        end
        mid[W_U] = half_sum(a_w[W_U], b_w[W_U]);
        mid[W_V] = half_sum(a_w[W_V], b_w[W_V]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.corner_we) begin
            r_corner[i_cmd.corner_slot] <= t_corner'(i_corner);
        end
        if (i_cmd.sq_en) begin
            r_len <= i_cmd.sq_first ? sq : (r_len + sq);
        end
        if (i_cmd.load_en) begin
            r_rhs <= ACC_W'(sq) << (2 * FRAC_BITS);
            r_p   <= '0;
            r_a   <= '0;
            r_b   <= ACC_W'(r_len) << (2 * FRAC_BITS);
            r_q   <= '0;
            r_bit <= Q_W'(1) << FRAC_BITS;
            r_neg <= s[SUM_W-1];
        end
        if (i_cmd.iter_en) begin
            if (fit) begin
                r_p <= t;
                r_a <= (r_a >> 1) + r_b;
                r_q <= r_q | r_bit;
            end else begin
                r_a <= r_a >> 1;
            end
            r_b   <= r_b >> 2;
            r_bit <= r_bit >> 1;
        end
        if (i_cmd.store_en) begin
            r_res[i_cmd.pair][i_cmd.vec][i_cmd.comp] <= res;
        end
        if (i_cmd.out_load) begin
            r_odata <= (i_cmd.out_sel < CNT_W'(3)) ? r_corner[i_cmd.out_sel[1:0]] : mid;
            r_olast <= i_cmd.out_last;
        end
    end

    assign o_data = r_odata;
    assign o_last = r_olast;

endmodule

FILE: rtl/mts_ctrl.sv
module mts_ctrl
    import mts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic [1:0]        r_phase, n_phase;
    logic [1:0]        r_m, n_m;
    logic              r_v, n_v;
    logic [1:0]        r_k, n_k;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_ovalid, n_ovalid;

    logic in_acc, emit;

    assign in_acc = (r_state == S_COLLECT) && i_in_valid;
    assign emit   = (r_state == S_EMIT) && (!r_ovalid || i_out_ready);

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_m      = r_m;
        n_v      = r_v;
        n_k      = r_k;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_ovalid = emit ? 1'b1 : (i_out_ready ? 1'b0 : r_ovalid);
        case (r_state)
            S_COLLECT: begin
                if (in_acc) begin
                    if (r_phase == 2'd2) begin
                        n_phase = 2'd0;
                        n_m     = 2'd0;
                        n_v     = 1'b0;
                        n_k     = 2'd0;
                        n_state = S_SQ;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            S_SQ: begin
                if (r_k == 2'd2) begin
                    n_k     = 2'd0;
                    n_state = S_LOAD;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_LOAD: begin
                n_step  = STEP_W'(FRAC_BITS);
                n_state = S_ITER;
            end
            S_ITER: begin
                if (r_step == '0) begin
                    n_state = S_STORE;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_STORE: begin
                if (r_k != 2'd2) begin
                    n_k     = r_k + 2'd1;
                    n_state = S_LOAD;
                end else if (!r_v) begin
                    n_k     = 2'd0;
                    n_v     = 1'b1;
                    n_state = S_SQ;
                end else if (r_m != 2'd2) begin
                    n_k     = 2'd0;
                    n_v     = 1'b0;
                    n_m     = r_m + 2'd1;
                    n_state = S_SQ;
                end else begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit) begin
                    n_cnt = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(RUN_LEN - 1)) begin
                        n_state = S_COLLECT;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.corner_we   = in_acc;
        o_cmd.corner_slot = r_phase;
        o_cmd.pair        = r_m;
        o_cmd.vec         = r_v;
        o_cmd.comp        = r_k;
        o_cmd.out_sel     = r_cnt;
        o_cmd.out_last    = (r_cnt == CNT_W'(RUN_LEN - 1));
        case (r_state)
            S_SQ: begin
                o_cmd.sq_en    = 1'b1;
                o_cmd.sq_first = (r_k == 2'd0);
            end
            S_LOAD: begin
                o_cmd.load_en = 1'b1;
            end
            S_ITER: begin
                o_cmd.iter_en = 1'b1;
            end
            S_STORE: begin
                o_cmd.store_en = 1'b1;
            end
            S_EMIT: begin
                o_cmd.out_load = emit;
                o_cmd.pair     = (r_cnt >= CNT_W'(3)) ? 2'(r_cnt - CNT_W'(3)) : 2'd0;
            end
            default: begin
                o_cmd.out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_COLLECT;
            r_phase  <= 2'd0;
            r_m      <= 2'd0;
            r_v      <= 1'b0;
            r_k      <= 2'd0;
            r_step   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_m      <= n_m;
            r_v      <= n_v;
            r_k      <= n_k;
            r_step   <= n_step;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_COLLECT);
    assign o_out_valid = r_ovalid;

endmodule

FILE: rtl/midpoint_triangle_subdivision_core.sv
// Midpoint subdivision of triangles, one corner vertex per input beat.
// Slave channel: one corner per beat (position, normal, tangent, uv, Q16.16).
// Master channel: six vertices per triangle: v0, v1, v2, then the midpoints
// of edges v0-v1, v1-v2 and v0-v2; tlast marks the sixth.
// The first two corners of a triangle are taken one per beat. After the
// third, the block computes six unit vectors (normal and tangent per midpoint)
// on one shared normalizer: per vector the squares of its three components
// are summed, then per component a load, FRAC_BITS+1 root-and-divide steps
// and a store. That normalizer loop sets the rate of triangles; each is then
// emitted as six output beats, one vertex per beat.
// The input is not ready while a triangle is computed or emitted; the last
// output beat may still wait while the next triangle's corners come in.
// Reset clears the corner count, the controller and the output valid.
// A receiver stall holds the output register and stops the emission.
module midpoint_triangle_subdivision_core
    import mts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tan_x, tan_y, tan_z, tex_u, tex_v
    input  logic [DATA_W-1:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // out_pos_x .. out_pos_z, out_norm_x .. out_norm_z, out_tan_x .. out_tan_z,
    // out_tex_u, out_tex_v
    output logic [DATA_W-1:0] o_m_axis_tdata,
    output logic              o_m_axis_tlast
);

    t_cmd cmd;

    mts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    mts_datapath u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_corner (i_s_axis_tdata),
        .o_data   (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast)
    );

endmodule
